@@ hdl/mjdcal_pkg.sv @@
// Shared constants, widths and tables for the MJD to calendar date converter.
`default_nettype none
package mjdcal_pkg;

  localparam int FRACTION_BITS = 16;

  localparam int MJD_W   = 17;
  localparam int WHOLE_W = 17;
  localparam int SOD_W   = WHOLE_W + FRACTION_BITS;
  localparam int YEAR_W  = 12;
  localparam int DOY_W   = 9;
  localparam int MON_W   = 4;
  localparam int MDAY_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SECI_W  = 6;
  localparam int SEC_W   = SECI_W + FRACTION_BITS;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 22;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [SOD_W-1:0] DAY_LIMIT = SOD_W'(86400) << FRACTION_BITS;

  localparam logic [MUL_A_W-1:0] EST_OFFSET  = MUL_A_W'(678940);
  localparam logic [MUL_A_W-1:0] JAN1_OFFSET = MUL_A_W'(678940);

  // reciprocals: q = (x * RECIP) >> SHIFT, exact over the operand range used
  localparam int SH_365  = 30;
  localparam logic [MUL_B_W-1:0] RECIP_365  = MUL_B_W'(2941759);
  localparam int SH_100  = 19;
  localparam logic [MUL_B_W-1:0] RECIP_100  = MUL_B_W'(5243);
  localparam int SH_3600 = 28;
  localparam logic [MUL_B_W-1:0] RECIP_3600 = MUL_B_W'(74566);
  localparam int SH_60   = 18;
  localparam logic [MUL_B_W-1:0] RECIP_60   = MUL_B_W'(4370);

  localparam logic [MON_W-1:0] LAST_MONTH_IDX = MON_W'(11);

  function automatic logic [MDAY_W-1:0] month_len(input logic [MON_W-1:0] idx,
                                                  input logic leap);
    logic [MDAY_W-1:0] len;
    unique case (idx)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

@@ hdl/mjdcal_if.sv @@
// Valid/ready channel interfaces for the date converter input and result beats.
`default_nettype none
interface mjdcal_in_if;
  logic                                valid;
  logic                                ready;
  logic [mjdcal_pkg::MJD_W-1:0]        mjd_day;
  logic [mjdcal_pkg::SOD_W-1:0]        seconds_of_day;

  modport source (output valid, output mjd_day, output seconds_of_day, input ready);
  modport sink   (input valid, input mjd_day, input seconds_of_day, output ready);
endinterface

interface mjdcal_out_if;
  logic                                valid;
  logic                                ready;
  logic [mjdcal_pkg::YEAR_W-1:0]       year;
  logic [mjdcal_pkg::DOY_W-1:0]        day_of_year;
  logic [mjdcal_pkg::MON_W-1:0]        month;
  logic [mjdcal_pkg::MDAY_W-1:0]       day_of_month;
  logic [mjdcal_pkg::HOUR_W-1:0]       hour;
  logic [mjdcal_pkg::MIN_W-1:0]        minute;
  logic [mjdcal_pkg::SEC_W-1:0]        second;

  modport source (output valid, output year, output day_of_year, output month,
                  output day_of_month, output hour, output minute, output second,
                  input ready);
  modport sink   (input valid, input year, input day_of_year, input month,
                  input day_of_month, input hour, input minute, input second,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/mjd_to_calendar_date.sv @@
// Top level: Modified Julian Day plus seconds of day to Gregorian date and time.
`default_nettype none
// Converts one beat (MJD day number, seconds of day with 16 fraction bits) into
// year, day of year, month, day of month, hour, minute and fractional second.
// Seconds of day at or past one full day saturate to 23:59 and the largest second.
// One beat is worked at a time through a single shared multiplier under a small
// sequencer: after the accept step come the year estimate, one or more years
// tried, the leap rule, a walk of one to twelve months and the time of day. The
// result sits in an output register, so a new beat is taken while it waits to be
// read; the next result holds in its last step until that register is free.
module mjd_to_calendar_date (
  input  wire logic   clk,
  input  wire logic   rst,
  mjdcal_in_if.sink   din,
  mjdcal_out_if.source dout
);
  import mjdcal_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_EST   = 12'b0000_0000_0010,
    S_YEAR  = 12'b0000_0000_0100,
    S_J1    = 12'b0000_0000_1000,
    S_J2    = 12'b0000_0001_0000,
    S_LEAP1 = 12'b0000_0010_0000,
    S_LEAP2 = 12'b0000_0100_0000,
    S_MONTH = 12'b0000_1000_0000,
    S_HOUR  = 12'b0001_0000_0000,
    S_HOUR2 = 12'b0010_0000_0000,
    S_MIN   = 12'b0100_0000_0000,
    S_MIN2  = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  logic [MJD_W-1:0]         mjd;
  logic [SOD_W-1:0]         sod;
  logic [YEAR_W-1:0]        year;
  logic [DOY_W-1:0]         doy;
  logic                     leap;
  logic [MON_W-1:0]         mon_idx;
  logic [DOY_W-1:0]         rem;
  logic [MON_W-1:0]         mon;
  logic [MDAY_W-1:0]        mday;
  logic [HOUR_W-1:0]        hour;
  logic [11:0]              sec_in_hour;
  logic [PROD_W-1:0]        prod;

  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic                     mul_en;
  logic [WHOLE_W-1:0]       whole;
  logic [YEAR_W-1:0]        p;
  logic [4:0]               q100;
  logic [19:0]              jan1;
  logic                     step_down;
  logic [4:0]               len;
  logic [HOUR_W-1:0]        hour_q;
  logic [MIN_W-1:0]         min_q;
  logic [6:0]               qy100;
  logic                     y100;
  logic                     finish;

  assign whole   = sod[SOD_W-1:FRACTION_BITS];
  assign p       = year - YEAR_W'(1);
  assign q100    = prod[SH_100+4:SH_100];
  assign jan1    = 20'(year) * 20'd365 + 20'(p[YEAR_W-1:2]) + 20'(q100[4:2])
                   - 20'(q100) - JAN1_OFFSET;
  // jan1 is negative (two's complement) for years that start before day 0
  assign step_down = !jan1[19] && (jan1 > 20'(mjd));
  assign len     = month_len(mon_idx, leap);
  assign hour_q  = prod[SH_3600+HOUR_W-1:SH_3600];
  assign min_q   = prod[SH_60+MIN_W-1:SH_60];
  assign qy100   = prod[SH_100+6:SH_100];
  assign y100    = (12'(qy100) * 12'd100) == year;
  assign finish  = !dout.valid || dout.ready;

  assign din.ready = (state == S_IDLE);

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state)
      S_EST: begin
        mul_a = MUL_A_W'(mjd) + EST_OFFSET;
        mul_b = RECIP_365;
      end
      S_J1: begin
        mul_a = MUL_A_W'(p);
        mul_b = RECIP_100;
      end
      S_LEAP1: begin
        mul_a = MUL_A_W'(year);
        mul_b = RECIP_100;
      end
      S_HOUR: begin
        mul_a = MUL_A_W'(whole);
        mul_b = RECIP_3600;
      end
      S_MIN: begin
        mul_a = MUL_A_W'(sec_in_hour);
        mul_b = RECIP_60;
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (din.valid) state_next = S_EST;
      S_EST:   state_next = S_YEAR;
      S_YEAR:  state_next = S_J1;
      S_J1:    state_next = S_J2;
      S_J2:    state_next = step_down ? S_J1 : S_LEAP1;
      S_LEAP1: state_next = S_LEAP2;
      S_LEAP2: state_next = S_MONTH;
      S_MONTH: begin
        if ((rem <= DOY_W'(len)) || (mon_idx == LAST_MONTH_IDX)) state_next = S_HOUR;
      end
      S_HOUR:  state_next = S_HOUR2;
      S_HOUR2: state_next = S_MIN;
      S_MIN:   state_next = S_MIN2;
      S_MIN2:  if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    unique case (state)
      S_IDLE: begin
        if (din.valid) begin
          mjd <= din.mjd_day;
          sod <= (din.seconds_of_day >= DAY_LIMIT) ? DAY_LIMIT - SOD_W'(1)
                                                    : din.seconds_of_day;
        end
      end
      S_YEAR: year <= prod[SH_365+YEAR_W-1:SH_365];
      S_J2: begin
        if (step_down) begin
          year <= year - YEAR_W'(1);
        end else begin
          doy <= DOY_W'(20'(mjd) - jan1 + 20'd1);
        end
      end
      S_LEAP2: begin
        leap    <= ((year[1:0] == 2'd0) && !y100) || (y100 && (qy100[1:0] == 2'd0));
        mon_idx <= '0;
        rem     <= doy;
      end
      S_MONTH: begin
        if (rem <= DOY_W'(len)) begin
          mon  <= mon_idx + MON_W'(1);
          mday <= rem[MDAY_W-1:0];
        end else begin
          rem     <= rem - DOY_W'(len);
          mon_idx <= mon_idx + MON_W'(1);
          if (mon_idx == LAST_MONTH_IDX) begin
            mon  <= MON_W'(12);
            mday <= MDAY_W'(rem - DOY_W'(len));
          end
        end
      end
      S_HOUR2: begin
        hour        <= hour_q;
        sec_in_hour <= 12'(whole - WHOLE_W'(hour_q) * WHOLE_W'(3600));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (state == S_MIN2 && finish) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MIN2 && finish) begin
      dout.year         <= year;
      dout.day_of_year  <= doy;
      dout.month        <= mon;
      dout.day_of_month <= mday;
      dout.hour         <= hour;
      dout.minute       <= min_q;
      dout.second       <= {SECI_W'(sec_in_hour - 12'(min_q) * 12'd60),
                            sod[FRACTION_BITS-1:0]};
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> state == S_EST)
    else $error("accepted beat did not start the sequencer");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> dout.month >= 4'd1 && dout.month <= 4'd12 &&
                   dout.day_of_month >= 5'd1 &&
                   dout.day_of_year >= 9'd1 && dout.day_of_year <= 9'd366)
    else $error("date fields out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> dout.hour <= 5'd23 && dout.minute <= 6'd59)
    else $error("time fields out of range");

  a_year_step_down: assert property (@(posedge clk) disable iff (rst)
    state == S_J2 && step_down |=> year == $past(year) - 12'd1)
    else $error("year correction did not step down");
`endif

endmodule
`default_nettype wire
